// File: hdl/esc_pkg.sv
// shared types, constants and helper functions of the environment sensor compensation unit
package esc_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_TEMP = 3'd0;
	localparam logic [2:0] REG_PRESS_A = 3'd1;
	localparam logic [2:0] REG_PRESS_B = 3'd2;
	localparam logic [2:0] REG_PRESS_LAST = 3'd3;
	localparam logic [2:0] REG_HUM_A = 3'd4;
	localparam logic [2:0] REG_HUM_B = 3'd5;

	// formula constants
	localparam logic [31:0] PRESS_OFS = 32'd64000;
	localparam logic [31:0] HUM_OFS = 32'd76800;
	localparam logic [31:0] HUM_MAX_SCALED = 32'd419430400;
	localparam logic [31:0] PRESS_BASE = 32'd1048576;
	localparam logic [31:0] PRESS_SCALE = 32'd3125;
	localparam logic [31:0] HUM_BIAS = 32'd2097152;
	localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
	localparam logic [31:0] RND_14 = 32'd16384;
	localparam logic [31:0] RND_15 = 32'd32768;
	localparam logic [31:0] RND_13 = 32'd8192;

	// queue depth and pipeline lengths
	localparam int QDEPTH = 4;
	localparam int FSTAGES = 12;
	localparam int DSTAGES = 32;
	localparam int PSTAGES = 3;

	// coefficients as 32-bit two's complement patterns
	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
	} coef_t;

	// one item handed from front to back
	typedef struct packed {
		logic [23:0] temp;
		logic [16:0] hum;
		logic        inv;
		logic        dbl;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} qitem_t;

	// arithmetic right shift of a 32-bit pattern
	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

// File: hdl/esc_front.sv
// front pipeline: temperature, humidity and the pressure terms up to the divisor
module esc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  esc_pkg::coef_t coef,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [19:0]    raw_temp,
	input  logic [19:0]    raw_press,
	input  logic [15:0]    raw_hum,
	output logic           push,
	input  logic           full,
	output esc_pkg::qitem_t item
);
	import esc_pkg::*;

	typedef struct packed {
		logic [19:0] adc_p;
		logic [15:0] adc_h;
		logic [31:0] a_t, dd, fine;
		logic [23:0] temp;
		logic [31:0] pa, q, r;
		logic [31:0] qq, ap5, p2a, hr, rh6, rh3;
		logic [31:0] b1, p3q, ha, hm;
		logic [31:0] b3, a2, hb1;
		logic [31:0] a3, hb2m;
		logic [31:0] dvs, hb, num;
		logic [31:0] hh, qq2, hsub;
		logic [16:0] hum;
	} fr_t;

	fr_t f_s [1:FSTAGES];
	fr_t f_d [1:FSTAGES];
	logic [FSTAGES:1] vld_q;
	logic [FSTAGES+1:1] en;

	logic [31:0] adc_t32, dt, q10, hr2;

	// stage enables: a stage moves when it is empty or its successor moves
	assign en[FSTAGES+1] = !full;
	genvar k;
	generate
		for (k = 1; k <= FSTAGES; k++) begin : g_en
			assign en[k] = !vld_q[k] || en[k+1];
		end
	endgenerate
	assign in_stall = !en[1];
	assign push = vld_q[FSTAGES] && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= in_valid;
			for (int i = 2; i <= FSTAGES; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// stage registers
	generate
		for (k = 1; k <= FSTAGES; k++) begin : g_stage
			always_ff @(posedge clk) begin
				if (en[k]) f_s[k] <= f_d[k];
			end
		end
	endgenerate

	assign adc_t32 = {12'd0, raw_temp};
	assign dt = (adc_t32 >> 4) - coef.t1;

	// s1: first temperature products
	always_comb begin
		f_d[1] = '0;
		f_d[1].adc_p = raw_press;
		f_d[1].adc_h = raw_hum;
		f_d[1].a_t = asr(((adc_t32 >> 3) - (coef.t1 << 1)) * coef.t2, 11);
		f_d[1].dd = dt * dt;
	end

	// s2: fine temperature
	always_comb begin
		f_d[2] = f_s[1];
		f_d[2].fine = f_s[1].a_t + asr(asr(f_s[1].dd, 12) * coef.t3, 14);
	end

	// s3: temperature result and offsets
	always_comb begin
		f_d[3] = f_s[2];
		f_d[3].temp = 24'(asr(f_s[2].fine * 32'd5 + 32'd128, 8));
		f_d[3].pa = asr(f_s[2].fine, 1) - PRESS_OFS;
		f_d[3].q = asr(asr(f_s[2].fine, 1) - PRESS_OFS, 2);
		f_d[3].r = f_s[2].fine - HUM_OFS;
	end

	// s4: products of the offsets
	always_comb begin
		f_d[4] = f_s[3];
		f_d[4].qq = f_s[3].q * f_s[3].q;
		f_d[4].ap5 = f_s[3].pa * coef.p5;
		f_d[4].p2a = coef.p2 * f_s[3].pa;
		f_d[4].hr = coef.h5 * f_s[3].r;
		f_d[4].rh6 = f_s[3].r * coef.h6;
		f_d[4].rh3 = f_s[3].r * coef.h3;
	end

	// s5: second level products
	always_comb begin
		f_d[5] = f_s[4];
		f_d[5].b1 = asr(f_s[4].qq, 11) * coef.p6;
		f_d[5].p3q = coef.p3 * asr(f_s[4].qq, 13);
		f_d[5].ha = asr(({16'd0, f_s[4].adc_h} << 14) - (coef.h4 << 20)
			- f_s[4].hr + RND_14, 15);
		f_d[5].hm = asr(f_s[4].rh6, 10) * (asr(f_s[4].rh3, 11) + RND_15);
	end

	// s6: sums of the pressure terms
	always_comb begin
		f_d[6] = f_s[5];
		f_d[6].b3 = asr(f_s[5].b1 + (f_s[5].ap5 << 1), 2) + (coef.p4 << 16);
		f_d[6].a2 = asr(asr(f_s[5].p3q, 3) + asr(f_s[5].p2a, 1), 18);
		f_d[6].hb1 = asr(f_s[5].hm, 10) + HUM_BIAS;
	end

	// s7: divisor product and humidity gain
	always_comb begin
		f_d[7] = f_s[6];
		f_d[7].a3 = (RND_15 + f_s[6].a2) * coef.p1;
		f_d[7].hb2m = f_s[6].hb1 * coef.h2;
	end

	// s8: divisor, scaled numerator
	always_comb begin
		f_d[8] = f_s[7];
		f_d[8].dvs = asr(f_s[7].a3, 15);
		f_d[8].hb = asr(f_s[7].hb2m + RND_13, 14);
		f_d[8].num = ((PRESS_BASE - {12'd0, f_s[7].adc_p}) - asr(f_s[7].b3, 12))
			* PRESS_SCALE;
	end

	// s9: humidity product
	always_comb begin
		f_d[9] = f_s[8];
		f_d[9].hh = f_s[8].ha * f_s[8].hb;
	end

	assign q10 = asr(f_s[9].hh, 15);

	// s10: humidity square
	always_comb begin
		f_d[10] = f_s[9];
		f_d[10].qq2 = q10 * q10;
	end

	// s11: humidity correction
	always_comb begin
		f_d[11] = f_s[10];
		f_d[11].hsub = asr(f_s[10].qq2, 7) * coef.h1;
	end

	assign hr2 = f_s[11].hh - asr(f_s[11].hsub, 4);

	// s12: clamp humidity
	always_comb begin
		f_d[12] = f_s[11];
		if (hr2[31]) f_d[12].hum = '0;
		else if (hr2 > HUM_MAX_SCALED) f_d[12].hum = 17'(HUM_MAX_SCALED >> 12);
		else f_d[12].hum = 17'(hr2 >> 12);
	end

	// item for the queue; a numerator with top bit set is divided first and doubled after
	always_comb begin
		item.temp = f_s[FSTAGES].temp;
		item.hum = f_s[FSTAGES].hum;
		item.inv = (f_s[FSTAGES].dvs == '0);
		item.dbl = (f_s[FSTAGES].num >= HALF_RANGE);
		item.dividend = item.dbl ? f_s[FSTAGES].num : (f_s[FSTAGES].num << 1);
		item.divisor = f_s[FSTAGES].dvs;
	end

endmodule

// File: hdl/esc_queue.sv
// small queue between front and back pipelines
module esc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  esc_pkg::qitem_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output esc_pkg::qitem_t rdata
);
	import esc_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	qitem_t mem_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hdl/esc_back.sv
// back pipeline: bit-per-stage pressure division and final pressure correction
module esc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  esc_pkg::coef_t  coef,
	input  logic            nonempty,
	input  esc_pkg::qitem_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [23:0]     temperature,
	output logic [31:0]     pressure,
	output logic            press_invalid,
	output logic [16:0]     humidity
);
	import esc_pkg::*;

	localparam int NST = DSTAGES + PSTAGES;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] nq;
		logic [31:0] div;
		logic        dbl;
		logic        inv;
		logic [23:0] temp;
		logic [16:0] hum;
	} dv_t;

	typedef struct packed {
		logic [31:0] p, ss, pb, a9;
		logic        inv;
		logic [23:0] temp;
		logic [16:0] hum;
	} po_t;

	dv_t dv_s [0:DSTAGES];
	po_t pb_s1, pb_s2, pb_s3;
	po_t pb_d2, pb_d3;
	logic [NST:1] vld_q;
	logic [NST+1:1] en;
	logic [31:0] p0;

	// stage enables
	assign en[NST+1] = !out_stall;
	genvar k;
	generate
		for (k = 1; k <= NST; k++) begin : g_en
			assign en[k] = !vld_q[k] || en[k+1];
		end
	endgenerate
	assign pop = nonempty && en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= nonempty;
			for (int i = 2; i <= NST; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// entry of the divider
	always_comb begin
		dv_s[0].rem = '0;
		dv_s[0].nq = head.dividend;
		dv_s[0].div = head.divisor;
		dv_s[0].dbl = head.dbl;
		dv_s[0].inv = head.inv;
		dv_s[0].temp = head.temp;
		dv_s[0].hum = head.hum;
	end

	// restoring division, one quotient bit per stage
	generate
		for (k = 1; k <= DSTAGES; k++) begin : g_div
			logic [32:0] trial;
			logic        take;
			dv_t         nxt;
			assign trial = {dv_s[k-1].rem, dv_s[k-1].nq[31]};
			assign take = (trial >= {1'b0, dv_s[k-1].div});
			always_comb begin
				nxt = dv_s[k-1];
				nxt.rem = take ? 32'(trial - {1'b0, dv_s[k-1].div}) : trial[31:0];
				nxt.nq = {dv_s[k-1].nq[30:0], take};
			end
			always_ff @(posedge clk) begin
				if (en[k]) dv_s[k] <= nxt;
			end
		end
	endgenerate

	assign p0 = dv_s[DSTAGES].dbl ? (dv_s[DSTAGES].nq << 1) : dv_s[DSTAGES].nq;

	// correction stage 1: square and p8 term
	always_ff @(posedge clk) begin
		if (en[DSTAGES+1]) begin
			pb_s1.p <= p0;
			pb_s1.ss <= (p0 >> 3) * (p0 >> 3);
			pb_s1.pb <= (p0 >> 2) * coef.p8;
			pb_s1.a9 <= '0;
			pb_s1.inv <= dv_s[DSTAGES].inv;
			pb_s1.temp <= dv_s[DSTAGES].temp;
			pb_s1.hum <= dv_s[DSTAGES].hum;
		end
	end

	// correction stage 2: p9 term
	always_comb begin
		pb_d2 = pb_s1;
		pb_d2.a9 = coef.p9 * (pb_s1.ss >> 13);
	end

	always_ff @(posedge clk) begin
		if (en[DSTAGES+2]) pb_s2 <= pb_d2;
	end

	// correction stage 3: output register
	always_comb begin
		pb_d3 = pb_s2;
		pb_d3.p = pb_s2.inv ? '0 : pb_s2.p
			+ asr(asr(pb_s2.a9, 12) + asr(pb_s2.pb, 13) + coef.p7, 4);
	end

	always_ff @(posedge clk) begin
		if (en[DSTAGES+3]) pb_s3 <= pb_d3;
	end

	assign out_valid = vld_q[NST];
	assign temperature = pb_s3.temp;
	assign pressure = pb_s3.p;
	assign press_invalid = pb_s3.inv;
	assign humidity = pb_s3.hum;

endmodule

// File: hdl/env_sensor_compensation_unit.sv
// top level of the environment sensor compensation unit
// Accepts one raw temperature/pressure/humidity triple per cycle and returns one
// compensated result per item, so the sustained rate is one item every cycle while
// out_stall is low. Items pass through the front pipeline (the chain of 32-bit
// multiplies through the temperature, pressure-divisor and humidity formulas),
// the 4-entry queue, the bit-per-stage pressure divider and final pressure correction.
// Coefficients are written through the register port; the user must do so while the
// block is idle, which the block itself does not enforce. All reset to zero.
module env_sensor_compensation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] raw_temp,
	input  logic [19:0] raw_press,
	input  logic [15:0] raw_hum,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [23:0] temperature,
	output logic [31:0] pressure,
	output logic        press_invalid,
	output logic [16:0] humidity
);
	import esc_pkg::*;

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_a_q, press_b_q;
	logic [15:0] press_last_q;
	logic [39:0] hum_a_q;
	logic [23:0] hum_b_q;
	coef_t coef;
	qitem_t fitem, qhead;
	logic push, full, pop, nonempty;
	logic [23:0] temp_u;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q <= '0;
			press_b_q <= '0;
			press_last_q <= '0;
			hum_a_q <= '0;
			hum_b_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TEMP: temp_coeffs_q <= wr_data[47:0];
				REG_PRESS_A: press_a_q <= wr_data;
				REG_PRESS_B: press_b_q <= wr_data;
				REG_PRESS_LAST: press_last_q <= wr_data[15:0];
				REG_HUM_A: hum_a_q <= wr_data[39:0];
				REG_HUM_B: hum_b_q <= wr_data[23:0];
				default: ;
			endcase
		end
	end

	// unpack coefficients
	always_comb begin
		coef.t1 = {16'd0, temp_coeffs_q[15:0]};
		coef.t2 = sx16(temp_coeffs_q[31:16]);
		coef.t3 = sx16(temp_coeffs_q[47:32]);
		coef.p1 = {16'd0, press_a_q[15:0]};
		coef.p2 = sx16(press_a_q[31:16]);
		coef.p3 = sx16(press_a_q[47:32]);
		coef.p4 = sx16(press_a_q[63:48]);
		coef.p5 = sx16(press_b_q[15:0]);
		coef.p6 = sx16(press_b_q[31:16]);
		coef.p7 = sx16(press_b_q[47:32]);
		coef.p8 = sx16(press_b_q[63:48]);
		coef.p9 = sx16(press_last_q);
		coef.h1 = {24'd0, hum_a_q[7:0]};
		coef.h2 = sx16(hum_a_q[23:8]);
		coef.h3 = {24'd0, hum_a_q[31:24]};
		coef.h6 = sx8(hum_a_q[39:32]);
		coef.h4 = {20'd0, hum_b_q[11:0]};
		coef.h5 = {20'd0, hum_b_q[23:12]};
	end

	esc_front u_front (
		.clk(clk), .arst_n(arst_n), .coef(coef),
		.in_valid(in_valid), .in_stall(in_stall),
		.raw_temp(raw_temp), .raw_press(raw_press), .raw_hum(raw_hum),
		.push(push), .full(full), .item(fitem)
	);

	esc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(fitem), .full(full),
		.pop(pop), .nonempty(nonempty), .rdata(qhead)
	);

	esc_back u_back (
		.clk(clk), .arst_n(arst_n), .coef(coef), .nonempty(nonempty), .head(qhead),
		.pop(pop), .out_valid(out_valid), .out_stall(out_stall),
		.temperature(temp_u), .pressure(pressure), .press_invalid(press_invalid),
		.humidity(humidity)
	);

	assign temperature = $signed(temp_u);

	// a transfer into the queue never happens while it is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");

	// humidity never leaves its clamped range
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity <= 17'd102400) else $error("humidity out of range");

	// an invalid pressure result reads as zero
	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_invalid |-> pressure == '0) else $error("invalid pressure not zero");

endmodule
